/* rtl/core/psq_pkg.sv */
// Package for the priority serve queue: request and status codes, shared types.
package psq_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_SERVE  = 2'd2;
  localparam logic [1:0] REQ_FIND   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_ORDER    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [3:0] RUN_LIMIT_RESET = 4'd3;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] customer_id;
    logic [10:0] arrival_minutes;
    logic        is_priority;
    logic        customer_class;
  } psq_req_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] served_id;
    logic [10:0] served_minutes;
    logic        served_priority;
    logic        served_class;
    logic [4:0]  found_position;
    logic [4:0]  occupancy;
  } psq_res_t;

endpackage

/* rtl/core/priority_serve_queue.sv */
// Top level of the priority serve queue: limit register, front and back parts.
//
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall   req_type, id, minutes, flags
// out_      output     out_valid / out_stall status, served entry, position, fill
// cfg_      input      cfg_we                priority_run_limit
//
// A transfer can be accepted every cycle while the result side is not stalled; a
// request passes through the front queue register and then the result register.
// The rate is set by the compacting shift register in the back.
// Reset is synchronous and active low; it empties the queue and sets the limit to 3.
// A stall on the result side holds the result register; the front queue of two
// entries keeps accepting until it is full.
module priority_serve_queue
  import psq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_customer_id,
  input  logic [10:0] in_arrival_minutes,
  input  logic        in_is_priority,
  input  logic        in_customer_class,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_served_id,
  output logic [10:0] out_served_minutes,
  output logic        out_served_priority,
  output logic        out_served_class,
  output logic [4:0]  out_found_position,
  output logic [4:0]  out_occupancy,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  logic [3:0] run_limit_r;
  psq_req_t   in_req, q_req;
  psq_res_t   res;
  logic       q_valid, q_take;

  // The user must write the limit register only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) run_limit_r <= RUN_LIMIT_RESET;
    else if (cfg_we) run_limit_r <= cfg_wdata;
  end

  assign in_req = '{req_type: in_req_type, customer_id: in_customer_id,
                    arrival_minutes: in_arrival_minutes,
                    is_priority: in_is_priority, customer_class: in_customer_class};

  psq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req(in_req), .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
  );

  psq_back #(.DEPTH(QUEUE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .run_limit(run_limit_r), .q_valid(q_valid),
    .q_take(q_take), .q_req(q_req), .res_valid(out_valid),
    .res_stall(out_stall), .res(res)
  );

  assign out_status          = res.status;
  assign out_served_id       = res.served_id;
  assign out_served_minutes  = res.served_minutes;
  assign out_served_priority = res.served_priority;
  assign out_served_class    = res.served_class;
  assign out_found_position  = res.found_position;
  assign out_occupancy       = res.occupancy;

  // Occupancy never exceeds the queue depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_occupancy) <= QUEUE_DEPTH))
    else $error("occupancy beyond depth");

  // A successful find reports a position and status ok together.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found_position != 5'd0) |-> (out_status == ST_OK))
    else $error("position with bad status");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_occupancy)))
    else $error("stalled result changed");

endmodule

/* rtl/core/psq_front.sv */
// Front part: accepts requests into a two-entry queue towards the back part.
module psq_front
  import psq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  psq_req_t in_req,
  output logic     q_valid,
  input  logic     q_take,
  output psq_req_t q_req
);

  psq_req_t   buf_r [2];
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_valid && q_take;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= in_req;
  end

endmodule

/* rtl/core/psq_back.sv */
// Back part: compacting shift-register queue that executes one request a cycle while the result is not stalled.
module psq_back
  import psq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] run_limit,
  input  logic       q_valid,
  output logic       q_take,
  input  psq_req_t   q_req,
  output logic       res_valid,
  input  logic       res_stall,
  output psq_res_t   res
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [15:0] id_r   [DEPTH];
  logic [10:0] min_r  [DEPTH];
  logic        prio_r [DEPTH];
  logic        cls_r  [DEPTH];
  logic [CW-1:0] fill_r;
  logic [3:0]    run_r;
  logic [10:0]   last_r;
  logic          res_valid_r;
  psq_res_t      res_r;

  logic [DEPTH-1:0] live, hit_p, hit_n, hit_id;
  logic [IW-1:0] idx_p, idx_n, idx_id, take_idx;
  logic any_p, any_n, any_id;
  logic go, do_take, do_ins;
  logic [3:0] run_nxt;
  psq_res_t res_nxt;
  logic [CW-1:0] fill_nxt;

  assign q_take    = !res_valid_r || !res_stall;
  assign go        = q_valid && q_take;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    idx_p = '0; idx_n = '0; idx_id = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      live[k]   = (CW'(k) < fill_r);
      hit_p[k]  = live[k] && prio_r[k];
      hit_n[k]  = live[k] && !prio_r[k];
      hit_id[k] = live[k] && (id_r[k] == q_req.customer_id);
      if (hit_p[k]) idx_p = IW'(k);
      if (hit_n[k]) idx_n = IW'(k);
      if (hit_id[k]) idx_id = IW'(k);
    end
    any_p  = |hit_p;
    any_n  = |hit_n;
    any_id = |hit_id;
  end

  always_comb begin
    res_nxt  = '0;
    do_take  = 1'b0;
    do_ins   = 1'b0;
    take_idx = '0;
    run_nxt  = run_r;
    fill_nxt = fill_r;
    res_nxt.status = ST_OK;
    unique case (q_req.req_type)
      REQ_INSERT: begin
        if (q_req.arrival_minutes < last_r) res_nxt.status = ST_ORDER;
        else if (fill_r >= CW'(DEPTH)) res_nxt.status = ST_FULL;
        else do_ins = 1'b1;
      end
      REQ_REMOVE: begin
        if (fill_r == '0) res_nxt.status = ST_EMPTY;
        else do_take = 1'b1;
      end
      REQ_SERVE: begin
        if (fill_r == '0) begin
          res_nxt.status = ST_EMPTY;
        end else if (run_r >= run_limit) begin
          do_take = 1'b1;
          take_idx = any_n ? idx_n : '0;
          run_nxt = '0;
        end else if (any_p) begin
          do_take = 1'b1;
          take_idx = idx_p;
          run_nxt = run_r + 4'd1;
        end else begin
          do_take = 1'b1;
          run_nxt = '0;
        end
      end
      REQ_FIND: begin
        if (any_id) begin
          res_nxt.served_minutes = min_r[idx_id];
          res_nxt.found_position = 5'(idx_id) + 5'd1;
        end else begin
          res_nxt.status = ST_NOTFOUND;
        end
      end
      default: res_nxt.status = ST_OK;
    endcase
    if (do_take) begin
      res_nxt.served_id       = id_r[take_idx];
      res_nxt.served_minutes  = min_r[take_idx];
      res_nxt.served_priority = prio_r[take_idx];
      res_nxt.served_class    = cls_r[take_idx];
      fill_nxt = fill_r - CW'(1);
    end
    if (do_ins) fill_nxt = fill_r + CW'(1);
    res_nxt.occupancy = 5'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      run_r       <= '0;
      last_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (go) begin
        fill_r <= fill_nxt;
        run_r  <= run_nxt;
        if (do_ins) last_r <= q_req.arrival_minutes;
        res_valid_r <= 1'b1;
      end else if (!res_stall) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) res_r <= res_nxt;
    for (int k = 0; k < DEPTH; k++) begin
      if (go && do_take && IW'(k) >= take_idx && k + 1 < DEPTH) begin
        id_r[k]   <= id_r[k+1];
        min_r[k]  <= min_r[k+1];
        prio_r[k] <= prio_r[k+1];
        cls_r[k]  <= cls_r[k+1];
      end else if (go && do_ins && CW'(k) == fill_r) begin
        id_r[k]   <= q_req.customer_id;
        min_r[k]  <= q_req.arrival_minutes;
        prio_r[k] <= q_req.is_priority;
        cls_r[k]  <= q_req.customer_class;
      end
    end
  end

endmodule
